FILE: hw/rtl/rrwlt_pkg.sv
package rrwlt_pkg;

	localparam int ROW_COUNT_DEF    = 1024;
	localparam int WAITER_SLOTS_DEF = 32;
	localparam int MAX_READERS_DEF  = 127;
	localparam int TAG_BITS_DEF     = 16;

	localparam int WAKE_LIMIT = 32;
	localparam int SLOT_W     = 6;
	localparam logic [SLOT_W-1:0] EMPTY_SLOT = 6'd63;

	localparam logic [1:0] MODE_ANY  = 2'd0;
	localparam logic [1:0] MODE_READ = 2'd1;
	localparam logic [1:0] MODE_STOP = 2'd2;

	typedef enum logic [1:0] {
		OP_RD_LOCK   = 2'd0,
		OP_WR_LOCK   = 2'd1,
		OP_RD_UNLOCK = 2'd2,
		OP_WR_UNLOCK = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		K_RD_GRANT  = 3'd0,
		K_WR_GRANT  = 3'd1,
		K_RD_WOKEN  = 3'd2,
		K_WR_WOKEN  = 3'd3,
		K_UNLOCKED  = 3'd4,
		K_MISUSE    = 3'd5,
		K_POOL_FULL = 3'd6,
		K_OVERFLOW  = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		RT_FIN  = 2'd0,
		RT_WROW = 2'd1,
		RT_WAKE = 2'd2
	} route_t;

	typedef struct packed {
		logic clr;
		logic accept;
		logic look;
		logic eval;
		logic wake_rd;
		logic wake_ev;
		logic wr_row;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic   clr_done;
		route_t ev_route;
		route_t wk_route;
		logic   head_ok;
		logic   can_push;
		logic   pend_v;
	} sts_t;

endpackage

FILE: hw/rtl/row_reader_writer_lock_table_unit.sv
// A lock or error result is offered after states LOOK, EVAL, then WROW or FIN.
// An unlock that frees a row also visits WAKE; each waiter examined adds WAKE and WEV.
// One item is in work at a time; the next word is accepted only once back in IDLE.
// After reset a clearing pass writes every row before the first item is accepted.
// The reset is asynchronous and clears the controller, the free-slot map and output valid.
module row_reader_writer_lock_table_unit
	import rrwlt_pkg::*;
#(
	parameter int ROW_COUNT    = ROW_COUNT_DEF,
	parameter int WAITER_SLOTS = WAITER_SLOTS_DEF,
	parameter int MAX_READERS  = MAX_READERS_DEF,
	parameter int TAG_BITS     = TAG_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // row in bits 9:0, tag in bits 25:10
	input  logic [1:0]  s_axis_tuser,  // operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // tag_out in bits 15:0, row_out in bits 25:16
	output logic [2:0]  m_axis_tuser,  // kind
	output logic        m_axis_tlast
);

	cmd_t        cmd;
	sts_t        sts;
	logic [15:0] tag_o;
	logic [9:0]  row_o;

	rrwlt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rrwlt_dp #(
		.ROW_COUNT    (ROW_COUNT),
		.WAITER_SLOTS (WAITER_SLOTS),
		.MAX_READERS  (MAX_READERS),
		.TAG_BITS     (TAG_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_op     (s_axis_tuser),
		.in_row    (s_axis_tdata[9:0]),
		.in_tag    (s_axis_tdata[25:10]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_tag   (tag_o),
		.out_row   (row_o),
		.out_kind  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {6'd0, row_o, tag_o};

endmodule

FILE: hw/rtl/rrwlt_ram.sv
module rrwlt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/rrwlt_ctrl.sv
module rrwlt_ctrl
	import rrwlt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_LOOK  = 8'b0000_0100,
		S_EVAL  = 8'b0000_1000,
		S_WAKE  = 8'b0001_0000,
		S_WEV   = 8'b0010_0000,
		S_WROW  = 8'b0100_0000,
		S_FIN   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_ok;

	assign in_ready = (state_q == S_IDLE);
	assign out_ok   = sts.can_push || !sts.pend_v;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.look = 1'b1;
				state_d  = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				case (sts.ev_route)
					RT_WROW: state_d = S_WROW;
					RT_WAKE: state_d = S_WAKE;
					default: state_d = S_FIN;
				endcase
			end
			S_WAKE: begin
				if (sts.head_ok) begin
					cmd.wake_rd = 1'b1;
					state_d     = S_WEV;
				end else begin
					state_d = S_WROW;
				end
			end
			S_WEV: begin
				if (sts.can_push) begin
					cmd.wake_ev = 1'b1;
					state_d     = (sts.wk_route == RT_WAKE) ? S_WAKE : S_WROW;
				end
			end
			S_WROW: begin
				if (out_ok) begin
					cmd.wr_row = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_FIN: begin
				if (out_ok) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hw/rtl/rrwlt_dp.sv
module rrwlt_dp
	import rrwlt_pkg::*;
#(
	parameter int ROW_COUNT    = ROW_COUNT_DEF,
	parameter int WAITER_SLOTS = WAITER_SLOTS_DEF,
	parameter int MAX_READERS  = MAX_READERS_DEF,
	parameter int TAG_BITS     = TAG_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [1:0]  in_op,
	input  logic [9:0]  in_row,
	input  logic [15:0] in_tag,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_tag,
	output logic [9:0]  out_row,
	output logic [2:0]  out_kind,
	output logic        out_last
);

	localparam int RA = $clog2(ROW_COUNT);
	localparam int SW = $clog2(WAITER_SLOTS);
	localparam int KB = (TAG_BITS < 16) ? TAG_BITS : 16;
	localparam int CW = $clog2(MAX_READERS + 1);
	localparam int RW = 1 + CW + 2 + 2 * SLOT_W;

	op_t               op_q;
	logic [9:0]        row_q;
	logic [KB-1:0]     tag_q;
	logic              wh_q;
	logic [CW-1:0]     cnt_q;
	logic [1:0]        mode_q;
	logic [SLOT_W-1:0] head_q, tail_q;
	logic              pend_v_q;
	logic [KB-1:0]     pend_tag_q;
	kind_t             pend_kind_q;
	logic              out_v_q, out_last_q;
	logic [KB-1:0]     out_tag_q;
	logic [9:0]        out_row_q;
	kind_t             out_kind_q;
	logic [WAITER_SLOTS-1:0] free_q;
	logic [5:0]        woken_q;
	logic [RA-1:0]     clr_q;

	logic [RW-1:0]     row_rdata, row_wdata, clr_rec;
	logic [RA-1:0]     row_waddr, row_raddr;
	logic [31:0]       in_row32, row_q32;
	logic [KB:0]       wd_rdata;
	logic [SLOT_W-1:0] nx_rdata;

	logic              fs_found;
	logic [SLOT_W-1:0] fs_idx;

	logic              in_range, cnt_max, held0, tail_ok, head_ok;
	route_t            ev_route, wk_route;
	logic              e_wh, e_alloc, e_link, e_pend;
	logic [CW-1:0]     e_cnt;
	logic [1:0]        e_mode;
	logic [SLOT_W-1:0] e_head, e_tail;
	kind_t             e_kind;
	logic              w_wh, w_push, w_deq;
	logic [CW-1:0]     w_cnt;
	logic [1:0]        w_mode;
	logic [SLOT_W-1:0] d_head, d_tail;
	kind_t             w_kind;
	logic              can_push, push, push_last;

	assign in_row32 = 32'(in_row);
	assign row_q32  = 32'(row_q);
	assign clr_rec  = {1'b0, {CW{1'b0}}, MODE_ANY, EMPTY_SLOT, EMPTY_SLOT};
	assign row_wdata = cmd.clr ? clr_rec : {wh_q, cnt_q, mode_q, head_q, tail_q};
	assign row_waddr = cmd.clr ? clr_q : row_q32[RA-1:0];
	assign row_raddr = in_row32[RA-1:0];

	rrwlt_ram #(.WIDTH(RW), .DEPTH(ROW_COUNT)) u_row_ram (
		.clk   (clk),
		.we    (cmd.clr || cmd.wr_row),
		.waddr (row_waddr),
		.wdata (row_wdata),
		.re    (cmd.accept),
		.raddr (row_raddr),
		.rdata (row_rdata)
	);

	rrwlt_ram #(.WIDTH(KB + 1), .DEPTH(WAITER_SLOTS)) u_wait_ram (
		.clk   (clk),
		.we    (cmd.eval && e_alloc),
		.waddr (fs_idx[SW-1:0]),
		.wdata ({(op_q == OP_WR_LOCK), tag_q}),
		.re    (cmd.wake_rd),
		.raddr (head_q[SW-1:0]),
		.rdata (wd_rdata)
	);

	rrwlt_ram #(.WIDTH(SLOT_W), .DEPTH(WAITER_SLOTS)) u_link_ram (
		.clk   (clk),
		.we    (cmd.eval && e_link),
		.waddr (tail_q[SW-1:0]),
		.wdata (fs_idx),
		.re    (cmd.wake_rd),
		.raddr (head_q[SW-1:0]),
		.rdata (nx_rdata)
	);

	always_comb begin
		fs_found = 1'b0;
		fs_idx   = '0;
		for (int i = WAITER_SLOTS - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				fs_found = 1'b1;
				fs_idx   = SLOT_W'(i);
			end
		end
	end

	assign in_range = row_q32 < 32'(ROW_COUNT);
	assign cnt_max  = 32'(cnt_q) >= 32'(MAX_READERS);
	assign held0    = !wh_q && (cnt_q == '0);
	assign tail_ok  = 32'(tail_q) < 32'(WAITER_SLOTS);
	assign head_ok  = 32'(head_q) < 32'(WAITER_SLOTS);

	always_comb begin
		ev_route = RT_FIN;
		e_wh     = wh_q;
		e_cnt    = cnt_q;
		e_mode   = mode_q;
		e_head   = head_q;
		e_tail   = tail_q;
		e_alloc  = 1'b0;
		e_link   = 1'b0;
		e_pend   = 1'b1;
		e_kind   = K_MISUSE;
		if (!in_range) begin
			e_kind = K_MISUSE;
		end else begin
			case (op_q)
				OP_RD_LOCK, OP_WR_LOCK: begin
					if (op_q == OP_RD_LOCK && !wh_q && mode_q != MODE_STOP) begin
						if (cnt_max) begin
							e_kind = K_OVERFLOW;
						end else begin
							e_cnt    = CW'(cnt_q + 1'b1);
							e_mode   = MODE_READ;
							e_kind   = K_RD_GRANT;
							ev_route = RT_WROW;
						end
					end else if (op_q == OP_WR_LOCK && mode_q == MODE_ANY && held0) begin
						e_wh     = 1'b1;
						e_cnt    = '0;
						e_mode   = MODE_STOP;
						e_kind   = K_WR_GRANT;
						ev_route = RT_WROW;
					end else if (!fs_found) begin
						e_kind = K_POOL_FULL;
					end else begin
						e_pend   = 1'b0;
						e_alloc  = 1'b1;
						e_link   = tail_ok;
						e_head   = tail_ok ? head_q : fs_idx;
						e_tail   = fs_idx;
						ev_route = RT_WROW;
					end
				end
				OP_RD_UNLOCK: begin
					if (!(wh_q || held0)) begin
						e_cnt    = CW'(cnt_q - 1'b1);
						e_kind   = K_UNLOCKED;
						ev_route = RT_WROW;
						if (cnt_q == CW'(1)) begin
							e_mode   = MODE_ANY;
							ev_route = RT_WAKE;
						end
					end
				end
				default: begin
					if (wh_q) begin
						e_wh     = 1'b0;
						e_cnt    = '0;
						e_mode   = MODE_ANY;
						e_kind   = K_UNLOCKED;
						ev_route = RT_WAKE;
					end
				end
			endcase
		end
	end

	assign d_head = (head_q == tail_q) ? EMPTY_SLOT : nx_rdata;
	assign d_tail = (head_q == tail_q) ? EMPTY_SLOT : tail_q;

	always_comb begin
		wk_route = RT_WROW;
		w_wh     = wh_q;
		w_cnt    = cnt_q;
		w_mode   = MODE_STOP;
		w_push   = 1'b0;
		w_deq    = 1'b0;
		w_kind   = K_RD_WOKEN;
		if (woken_q == '0 && wd_rdata[KB]) begin
			w_push = 1'b1;
			w_deq  = 1'b1;
			w_kind = K_WR_WOKEN;
			w_wh   = 1'b1;
			w_cnt  = '0;
		end else if (!(wd_rdata[KB] || cnt_max || 32'(woken_q) >= 32'(WAKE_LIMIT))) begin
			w_push   = 1'b1;
			w_deq    = 1'b1;
			w_cnt    = CW'(cnt_q + 1'b1);
			w_mode   = MODE_READ;
			wk_route = RT_WAKE;
		end
	end

	assign can_push  = !out_v_q || out_ready;
	assign push      = pend_v_q && ((cmd.wake_ev && w_push) || cmd.wr_row || cmd.fin);
	assign push_last = cmd.wr_row || cmd.fin;

	assign sts.clr_done = (clr_q == RA'(ROW_COUNT - 1));
	assign sts.ev_route = ev_route;
	assign sts.wk_route = wk_route;
	assign sts.head_ok  = head_ok;
	assign sts.can_push = can_push;
	assign sts.pend_v   = pend_v_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= op_t'(in_op);
			row_q <= in_row;
			tag_q <= in_tag[KB-1:0];
		end
		if (cmd.look) begin
			{wh_q, cnt_q, mode_q, head_q, tail_q} <= row_rdata;
		end
		if (cmd.eval) begin
			wh_q        <= e_wh;
			cnt_q       <= e_cnt;
			mode_q      <= e_mode;
			head_q      <= e_head;
			tail_q      <= e_tail;
			pend_tag_q  <= tag_q;
			pend_kind_q <= e_kind;
			woken_q     <= '0;
		end
		if (cmd.wake_ev) begin
			wh_q   <= w_wh;
			cnt_q  <= w_cnt;
			mode_q <= w_mode;
			if (w_deq) begin
				head_q  <= d_head;
				tail_q  <= d_tail;
				woken_q <= woken_q + 6'd1;
			end
			if (w_push) begin
				pend_tag_q  <= wd_rdata[KB-1:0];
				pend_kind_q <= w_kind;
			end
		end
		if (push) begin
			out_tag_q  <= pend_tag_q;
			out_row_q  <= row_q;
			out_kind_q <= pend_kind_q;
			out_last_q <= push_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			free_q   <= '1;
			clr_q    <= '0;
		end else begin
			if (cmd.clr && !sts.clr_done) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.eval) begin
				pend_v_q <= e_pend;
			end else if (cmd.wr_row || cmd.fin) begin
				pend_v_q <= 1'b0;
			end
			if (push) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			if (cmd.eval && e_alloc) begin
				free_q[fs_idx[SW-1:0]] <= 1'b0;
			end
			if (cmd.wake_ev && w_deq) begin
				free_q[head_q[SW-1:0]] <= 1'b1;
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_tag   = 16'(32'(out_tag_q));
	assign out_row   = out_row_q;
	assign out_kind  = out_kind_q;
	assign out_last  = out_last_q;

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!out_v_q || out_ready))
		else $error("result pushed over an untaken result");

	a_write_held_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval |-> !(wh_q && cnt_q != '0))
		else $error("write-held row carries a reader count");

	a_woken_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wake_ev |-> 32'(woken_q) <= 32'(WAKE_LIMIT))
		else $error("wake run exceeded its limit");

	a_ack_first: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wake_rd |-> pend_v_q)
		else $error("wake started without an unlock acknowledgement");

endmodule

FILE: bench/row_reader_writer_lock_table_unit_test.sv
module row_reader_writer_lock_table_unit_test;
	import rrwlt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROWS = 1024;
	localparam int SLOTS = 32;
	localparam int MAXRD = 127;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [15:0] HELD = 16'hFFFF;

	typedef struct {
		logic [15:0] tag;
		logic [9:0]  row;
		kind_t       kind;
		logic        last;
	} lock_reply_t;

	class lock_table_scoreboard;
		logic [15:0] holders[ROWS];
		logic [1:0]  mode[ROWS];
		int          waiters[ROWS][$];
		int          pool_used;
		lock_reply_t replies[$];
		int          errors;

		function void clear();
			for (int r = 0; r < ROWS; r++) begin
				holders[r] = 0;
				mode[r] = MODE_ANY;
				waiters[r].delete();
			end
			pool_used = 0;
			replies.delete();
			errors = 0;
		endfunction

		function void push(logic [15:0] t, logic [9:0] r, kind_t k);
			lock_reply_t x;
			x.tag = t;
			x.row = r;
			x.kind = k;
			x.last = 1'b0;
			replies.push_back(x);
		endfunction

		// Waiter queue entries: bit 16 marks a writer, low 16 bits hold the tag.
		function void enqueue_or_full(logic [15:0] t, logic [9:0] r, bit wr);
			if (pool_used >= SLOTS) begin
				push(t, r, K_POOL_FULL);
			end else begin
				pool_used++;
				waiters[r].push_back({wr, t});
			end
		endfunction

		function void wake_row(logic [9:0] r);
			int n;
			n = 0;
			if (holders[r] != 0 || waiters[r].size() == 0) return;
			if (waiters[r][0][16]) begin
				push(waiters[r][0][15:0], r, K_WR_WOKEN);
				holders[r] = HELD;
				mode[r] = MODE_STOP;
				void'(waiters[r].pop_front());
				pool_used--;
				return;
			end
			while (waiters[r].size() > 0 && !waiters[r][0][16] && holders[r] < MAXRD
					&& n < WAKE_LIMIT) begin
				push(waiters[r][0][15:0], r, K_RD_WOKEN);
				holders[r]++;
				mode[r] = MODE_READ;
				void'(waiters[r].pop_front());
				pool_used--;
				n++;
			end
			if (waiters[r].size() > 0) mode[r] = MODE_STOP;
		endfunction

		function void note_request(op_t op, logic [9:0] r, logic [15:0] t);
			int start_count;
			start_count = replies.size();
			case (op)
				OP_RD_LOCK: begin
					if (holders[r] != HELD && mode[r] != MODE_STOP) begin
						if (holders[r] >= MAXRD) begin
							push(t, r, K_OVERFLOW);
						end else begin
							holders[r]++;
							mode[r] = MODE_READ;
							push(t, r, K_RD_GRANT);
						end
					end else begin
						enqueue_or_full(t, r, 0);
					end
				end
				OP_WR_LOCK: begin
					if (mode[r] == MODE_ANY && holders[r] == 0) begin
						holders[r] = HELD;
						mode[r] = MODE_STOP;
						push(t, r, K_WR_GRANT);
					end else begin
						enqueue_or_full(t, r, 1);
					end
				end
				OP_RD_UNLOCK: begin
					if (holders[r] == 0 || holders[r] == HELD) begin
						push(t, r, K_MISUSE);
					end else begin
						holders[r]--;
						push(t, r, K_UNLOCKED);
						if (holders[r] == 0) begin
							mode[r] = MODE_ANY;
							wake_row(r);
						end
					end
				end
				default: begin
					if (holders[r] != HELD) begin
						push(t, r, K_MISUSE);
					end else begin
						holders[r] = 0;
						mode[r] = MODE_ANY;
						push(t, r, K_UNLOCKED);
						wake_row(r);
					end
				end
			endcase
			if (replies.size() > start_count) replies[replies.size() - 1].last = 1'b1;
		endfunction

		task report(string msg);
			$display("%s", msg);
			errors++;
		endtask

		task check_reply(lock_reply_t got);
			lock_reply_t want;
			if (replies.size() == 0) begin
				report($sformatf("unexpected word: tag %h row %0d kind %0d",
					got.tag, got.row, got.kind));
				return;
			end
			want = replies.pop_front();
			if (got.tag !== want.tag || got.row !== want.row || got.kind !== want.kind
					|| got.last !== want.last) begin
				report($sformatf("mismatch: got tag %h row %0d kind %0d last %b, want %h %0d %0d %b",
					got.tag, got.row, got.kind, got.last,
					want.tag, want.row, want.kind, want.last));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;

	lock_table_scoreboard board;
	int idle_cycles;
	int sink_stall;
	bit sink_hold;

	row_reader_writer_lock_table_unit uut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		return $urandom_range(0, 3);
	endfunction

	task automatic send_request(op_t op, logic [9:0] r, logic [15:0] t);
		int g;
		g = (sink_hold) ? 0 : gap_len();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {6'd0, t, r};
		do @(posedge clk); while (!s_axis_tready);
		board.note_request(op, r, t);
		@(negedge clk);
	endtask

	task automatic drain_all();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (board.replies.size() > 0);
	endtask

	always @(posedge clk) begin
		lock_reply_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.tag = m_axis_tdata[15:0];
			got.row = m_axis_tdata[25:16];
			got.kind = kind_t'(m_axis_tuser);
			got.last = m_axis_tlast;
			board.check_reply(got);
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b1;
			sink_stall <= 0;
		end else if (sink_stall > 0) begin
			m_axis_tready <= 1'b0;
			sink_stall <= sink_stall - 1;
		end else if ($urandom_range(0, 4) == 0) begin
			m_axis_tready <= 1'b1;
		end else if ($urandom_range(0, 60) == 0) begin
			m_axis_tready <= 1'b0;
			sink_stall <= $urandom_range(10, 40);
		end else begin
			m_axis_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [9:0] hot;
		int k;
		board = new();
		board.clear();
		idle_cycles = -2000;
		sink_hold = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_RD_LOCK;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		send_request(OP_RD_UNLOCK, 10'd0, 16'h0000);
		send_request(OP_WR_UNLOCK, 10'd1023, 16'hFFFF);
		send_request(OP_RD_LOCK, 10'd5, 16'h1111);
		send_request(OP_WR_LOCK, 10'd5, 16'h2222);
		send_request(OP_RD_LOCK, 10'd5, 16'h3333);
		send_request(OP_RD_LOCK, 10'd5, 16'h4444);
		send_request(OP_WR_UNLOCK, 10'd5, 16'h5555);
		send_request(OP_RD_UNLOCK, 10'd5, 16'h6666);
		send_request(OP_WR_UNLOCK, 10'd5, 16'h7777);
		send_request(OP_RD_UNLOCK, 10'd5, 16'h8888);
		send_request(OP_RD_UNLOCK, 10'd5, 16'h9999);
		send_request(OP_WR_LOCK, 10'd1023, 16'hAAAA);
		for (k = 0; k < 34; k++) send_request(OP_RD_LOCK, 10'd1023, 16'(k));
		send_request(OP_WR_UNLOCK, 10'd1023, 16'hFFFF);
		for (k = 0; k < 128; k++) send_request(OP_RD_LOCK, 10'd7, 16'(k + 16'h100));
		for (k = 0; k < 127; k++) send_request(OP_RD_UNLOCK, 10'd7, 16'hABCD);

		sink_hold = 1;
		drain_all();
		sink_hold = 0;

		for (k = 0; k < 60; k++) begin
			hot = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 7));
			send_request(op_t'($urandom_range(0, 3)), hot, 16'($urandom));
		end

		drain_all();
		repeat (50) @(negedge clk);
		if (board.errors == 0 && board.replies.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/rrwlt_pkg.sv
hw/rtl/rrwlt_ram.sv
hw/rtl/rrwlt_ctrl.sv
hw/rtl/rrwlt_dp.sv
hw/rtl/row_reader_writer_lock_table_unit.sv
bench/row_reader_writer_lock_table_unit_test.sv
